// ----- sv/md5sh_pkg.sv -----
// md5sh_pkg: shared types and constants of the streaming md5 hasher
// (queue item, digest beat, round constants, shift amounts, message schedule).
// No dependencies; the front, queue, back end and top refer to it by scoped names.
package md5sh_pkg;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  count;
      logic        first;
      logic        last;
   } md5sh_item_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [1:0]  word_index;
      logic        digest_done;
   } md5sh_digest_type;

   localparam logic [31:0] CHAIN_INIT [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   localparam logic [7:0] PAD_MARK  = 8'h80;
   localparam logic [2:0] MAX_BYTES = 3'd4;

   localparam logic [31:0] ROUND_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // indexed by {round group, round[1:0]}
   localparam logic [4:0] ROT_AMT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // message word used by a round
   function automatic logic [3:0] msg_index(input logic [5:0] rnd);
      logic [3:0] q;
      q = rnd[3:0];
      case (rnd[5:4])
         2'd0:    return q;
         2'd1:    return 4'(q * 4'd5 + 4'd1);
         2'd2:    return 4'(q * 4'd3 + 4'd5);
         default: return 4'(q * 4'd7);
      endcase
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
      logic [63:0] dbl;
      dbl = {v, v} << s;
      return dbl[63:32];
   endfunction

endpackage

// ----- sv/md5sh_if.sv -----
// md5sh_if: valid/ready channel interfaces of the md5 hasher
// (message word channel and digest channel). No dependencies.
interface md5sh_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic [2:0]  valid_bytes;
   logic        first_word;
   logic        last_word;

   modport source(output valid, data_word, valid_bytes, first_word, last_word, input ready);
   modport sink(input valid, data_word, valid_bytes, first_word, last_word, output ready);
endinterface

interface md5sh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [1:0]  word_index;
   logic        digest_done;

   modport source(output valid, digest_word, word_index, digest_done, input ready);
   modport sink(input valid, digest_word, word_index, digest_done, output ready);
endinterface

// ----- sv/md5sh_front.sv -----
// md5sh_front: takes message word beats and classifies them into queue items
// (byte count clamped to a word). Depends on md5sh_pkg and md5sh_if.
module md5sh_front (
   md5sh_req_if.sink               req_ch,
   input  logic                    q_space,
   output logic                    push,
   output md5sh_pkg::md5sh_item_type push_item
);

   assign req_ch.ready = q_space;
   assign push         = req_ch.valid && q_space;

   always_comb begin
      push_item.word  = req_ch.data_word;
      // counts above a full word mean a full word
      push_item.count = (req_ch.valid_bytes > md5sh_pkg::MAX_BYTES) ?
                        md5sh_pkg::MAX_BYTES : req_ch.valid_bytes;
      push_item.first = req_ch.first_word;
      push_item.last  = req_ch.last_word;
   end

endmodule

// ----- sv/md5sh_queue.sv -----
// md5sh_queue: short fifo of classified items between front and back end.
// Depends on md5sh_pkg.
module md5sh_queue #(
   parameter int DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  md5sh_pkg::md5sh_item_type push_item,
   output logic                      space,
   input  logic                      pop,
   output logic                      q_valid,
   output md5sh_pkg::md5sh_item_type q_item
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   md5sh_pkg::md5sh_item_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign space   = (count_ff != CNT_W'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- sv/md5sh_back.sv -----
// md5sh_back: block buffer, padding sequencer, one-round-per-cycle md5
// compressor and digest output register. Depends on md5sh_pkg.
module md5sh_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  md5sh_pkg::md5sh_item_type   q_item,
   output logic                        pop,
   output logic                        rsp_valid,
   output md5sh_pkg::md5sh_digest_type rsp_data,
   input  logic                        rsp_ready
);

   localparam logic [5:0] LEN_POS   = 6'd56;
   localparam logic [6:0] BLK_BYTES = 7'd64;
   localparam logic [3:0] LEN_LO    = 4'd14;
   localparam logic [3:0] LEN_HI    = 4'd15;
   localparam logic [5:0] LAST_RND  = 6'd63;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_APPEND,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_PREP,
      ST_ROUND,
      ST_FOLD,
      ST_DIGEST
   } state_type;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] len_ff, len_in;
   logic [31:0] chain_ff [4];
   logic [31:0] chain_in [4];
   logic [5:0]  rnd_ff, rnd_in;
   logic [1:0]  dig_idx_ff, dig_idx_in;
   logic        out_valid_ff, out_valid_in;
   md5sh_pkg::md5sh_digest_type out_ff, out_in;

   logic [31:0] work_ff [4];
   logic [31:0] work_in [4];
   logic [31:0] km_ff, km_in;
   logic [31:0] block_ff [16];
   logic [31:0] block_in [16];
   logic [31:0] word_ff, word_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        last_ff, last_in;

   // buffer write request
   logic        wr_en;
   logic [31:0] wr_src;
   logic [6:0]  wr_n;
   logic        len_wr;

   logic [6:0]  space;
   logic [6:0]  take_n;
   logic        blk_full;
   logic [5:0]  km_rnd;
   logic [31:0] km_next;
   logic [31:0] f_val;
   logic [31:0] t_val;

   assign space    = BLK_BYTES - {1'b0, fill_ff};
   assign take_n   = ({4'b0, cnt_ff} < space) ? {4'b0, cnt_ff} : space;
   assign blk_full = ({1'b0, fill_ff} + take_n) == BLK_BYTES;

   // constant plus message word for the coming round
   assign km_rnd  = (state_ff == ST_PREP) ? 6'd0 : rnd_ff + 6'd1;
   assign km_next = md5sh_pkg::ROUND_K[km_rnd] + block_ff[md5sh_pkg::msg_index(km_rnd)];

   always_comb begin
      case (rnd_ff[5:4])
         2'd0:    f_val = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
         2'd1:    f_val = (work_ff[3] & work_ff[1]) | (~work_ff[3] & work_ff[2]);
         2'd2:    f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         default: f_val = work_ff[2] ^ (work_ff[1] | ~work_ff[3]);
      endcase
   end

   assign t_val = work_ff[0] + f_val + km_ff;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      fill_in      = fill_ff;
      len_in       = len_ff;
      chain_in     = chain_ff;
      rnd_in       = rnd_ff;
      dig_idx_in   = dig_idx_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      work_in      = work_ff;
      km_in        = km_ff;
      word_in      = word_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      wr_en        = 1'b0;
      wr_src       = '0;
      wr_n         = '0;
      len_wr       = 1'b0;
      pop          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            pop = q_valid;
         end
         ST_APPEND: begin
            // as many bytes as fit in the current block
            wr_en   = 1'b1;
            wr_src  = word_ff;
            wr_n    = take_n;
            word_in = word_ff >> {take_n[2:0], 3'b000};
            cnt_in  = cnt_ff - take_n[2:0];
            fill_in = fill_ff + take_n[5:0];
            if (blk_full) begin
               state_in = ST_PREP;
               ret_in   = ST_APPEND;
            end else if (cnt_ff == take_n[2:0]) begin
               if (last_ff) begin
                  state_in = ST_PAD_MARK;
               end else begin
                  state_in = ST_IDLE;
                  pop      = q_valid;
               end
            end
         end
         ST_PAD_MARK: begin
            wr_en   = 1'b1;
            wr_src  = {24'b0, md5sh_pkg::PAD_MARK};
            wr_n    = 7'd1;
            fill_in = fill_ff + 6'd1;
            if (fill_ff == LAST_RND) begin
               state_in = ST_PREP;
               ret_in   = ST_PAD_ZERO;
            end else begin
               state_in = ST_PAD_ZERO;
            end
         end
         ST_PAD_ZERO: begin
            wr_en = 1'b1;
            if (fill_ff <= LEN_POS) begin
               wr_n     = {1'b0, LEN_POS} - {1'b0, fill_ff};
               fill_in  = LEN_POS;
               state_in = ST_PAD_LEN;
            end else begin
               // no room for the length: zero this block, pad the next
               wr_n     = space;
               fill_in  = '0;
               state_in = ST_PREP;
               ret_in   = ST_PAD_ZERO;
            end
         end
         ST_PAD_LEN: begin
            len_wr   = 1'b1;
            fill_in  = '0;
            state_in = ST_PREP;
            ret_in   = ST_DIGEST;
         end
         ST_PREP: begin
            work_in  = chain_ff;
            rnd_in   = '0;
            km_in    = km_next;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            work_in[0] = work_ff[3];
            work_in[1] = work_ff[1] + md5sh_pkg::rotl32(t_val,
                            md5sh_pkg::ROT_AMT[{rnd_ff[5:4], rnd_ff[1:0]}]);
            work_in[2] = work_ff[1];
            work_in[3] = work_ff[2];
            km_in      = km_next;
            rnd_in     = rnd_ff + 6'd1;
            if (rnd_ff == LAST_RND) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            for (int i = 0; i < 4; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            rnd_in   = '0;
            state_in = ret_ff;
         end
         ST_DIGEST: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in       = 1'b1;
               out_in.digest_word = chain_ff[dig_idx_ff];
               out_in.word_index  = dig_idx_ff;
               out_in.digest_done = (dig_idx_ff == 2'd3);
               dig_idx_in         = dig_idx_ff + 2'd1;
               if (dig_idx_ff == 2'd3) begin
                  // message done: next beat opens a new one
                  chain_in = md5sh_pkg::CHAIN_INIT;
                  fill_in  = '0;
                  len_in   = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (pop) begin
         word_in  = q_item.word;
         cnt_in   = q_item.count;
         last_in  = q_item.last;
         state_in = ST_APPEND;
         if (q_item.first) begin
            chain_in = md5sh_pkg::CHAIN_INIT;
            fill_in  = '0;
            len_in   = {58'b0, q_item.count, 3'b000};
         end else begin
            len_in = len_ff + {58'b0, q_item.count, 3'b000};
         end
      end
   end

   // byte-enable write into the block buffer starting at the fill offset
   always_comb begin
      logic [5:0] pos;
      logic [5:0] off;
      block_in = block_ff;
      for (int w = 0; w < 16; w++) begin
         for (int b = 0; b < 4; b++) begin
            pos = 6'(w * 4 + b);
            off = pos - fill_ff;
            if (wr_en && ({1'b0, off} < wr_n)) begin
               block_in[w][8*b +: 8] = wr_src[{off[1:0], 3'b000} +: 8];
            end
         end
      end
      if (len_wr) begin
         block_in[LEN_LO] = len_ff[31:0];
         block_in[LEN_HI] = len_ff[63:32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         fill_ff      <= '0;
         len_ff       <= '0;
         chain_ff     <= md5sh_pkg::CHAIN_INIT;
         rnd_ff       <= '0;
         dig_idx_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         fill_ff      <= fill_in;
         len_ff       <= len_in;
         chain_ff     <= chain_in;
         rnd_ff       <= rnd_in;
         dig_idx_ff   <= dig_idx_in;
         out_valid_ff <= out_valid_in;
         out_ff       <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      km_ff    <= km_in;
      block_ff <= block_in;
      word_ff  <= word_in;
      cnt_ff   <= cnt_in;
      last_ff  <= last_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ----- sv/md5_stream_hasher.sv -----
// md5_stream_hasher: top level of the streaming md5 engine.
// Depends on md5sh_pkg, md5sh_if, md5sh_front, md5sh_queue and md5sh_back.
//
// Message bytes come in as beats of 1 to 4 little-endian bytes; first_word
// restarts the hash, last_word pads the message (0x80, zeros, 64-bit bit
// length) and sends the 128-bit digest as four beats, word 0 first, with
// digest_done on the fourth. After a digest the next beat starts a new
// message even without first_word. Accepted beats wait in a short queue
// (QUEUE_DEPTH entries, at least 2) while the back end works, so the input
// only stalls when that queue is full. The back end appends one beat per
// cycle into a 64-byte block buffer while no block is being compressed,
// and compresses each full block as setup, 64 rounds at one round per
// cycle, and a fold into the chaining value; no beat leaves the queue
// while a block is compressed. A last beat adds padding steps and one or
// two block compressions before the first digest beat, then one digest
// beat per cycle while the consumer is ready.
module md5_stream_hasher #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   md5sh_req_if.sink   req_ch,
   md5sh_rsp_if.source rsp_ch
);

   logic                        q_space;
   logic                        push;
   md5sh_pkg::md5sh_item_type   push_item;
   logic                        q_valid;
   logic                        q_pop;
   md5sh_pkg::md5sh_item_type   q_item;
   md5sh_pkg::md5sh_digest_type rsp_data;

   md5sh_front u_front (
      .req_ch    (req_ch),
      .q_space   (q_space),
      .push      (push),
      .push_item (push_item)
   );

   md5sh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .space     (q_space),
      .pop       (q_pop),
      .q_valid   (q_valid),
      .q_item    (q_item)
   );

   md5sh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .pop       (q_pop),
      .rsp_valid (rsp_ch.valid),
      .rsp_data  (rsp_data),
      .rsp_ready (rsp_ch.ready)
   );

   assign rsp_ch.digest_word = rsp_data.digest_word;
   assign rsp_ch.word_index  = rsp_data.word_index;
   assign rsp_ch.digest_done = rsp_data.digest_done;

   // the four digest beats leave back to back once the consumer takes them
   a_digest_burst : assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !rsp_ch.digest_done) |=> rsp_ch.valid)
      else $error("digest beat missing after a non-final digest beat");

   a_digest_order : assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !rsp_ch.digest_done) |=>
      (rsp_ch.word_index == $past(rsp_ch.word_index) + 2'd1))
      else $error("digest words out of order");

   // no new item enters the back end before the last digest beat is on the channel
   a_no_pop_in_digest : assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.digest_done) |-> !(q_valid && q_pop))
      else $error("queue popped while digest in flight");

   a_pop_needs_item : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

endmodule
